// File: hdl/svm_pkg.sv
// shared types and constants for the stereo voice mixer
package svm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int PAN_W    = 17;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 34;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 17;
    localparam int VOICE_SLOTS = 4;

    localparam logic [GAIN_W-1:0] Q15_ONE = 16'd32768;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE0_GAIN = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE1_GAIN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE2_GAIN = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE3_GAIN = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE0_PAN  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE1_PAN  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE2_PAN  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_VOICE3_PAN  = 4'd7;

    typedef struct packed {
        logic [1:0]                 voice;
        logic signed [SAMPLE_W-1:0] sample_left;
        logic signed [SAMPLE_W-1:0] sample_right;
        logic                       mono;
        logic                       last_in_frame;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } out_word_t;

    typedef struct packed {
        logic [VOICE_SLOTS-1:0][GAIN_W-1:0] gain;
        logic [VOICE_SLOTS-1:0][PAN_W-1:0]  pan;
    } cfg_regs_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_l;
        logic [GAIN_W-1:0] gain_r;
    } eff_gain_t;

endpackage

// File: hdl/svm_cfg_regs.sv
// gain and pan configuration registers
module svm_cfg_regs
    import svm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_regs_t             regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_VOICE0_GAIN: regs_next.gain[0] = cfg_data[GAIN_W-1:0];
                CFG_VOICE1_GAIN: regs_next.gain[1] = cfg_data[GAIN_W-1:0];
                CFG_VOICE2_GAIN: regs_next.gain[2] = cfg_data[GAIN_W-1:0];
                CFG_VOICE3_GAIN: regs_next.gain[3] = cfg_data[GAIN_W-1:0];
                CFG_VOICE0_PAN:  regs_next.pan[0]  = cfg_data[PAN_W-1:0];
                CFG_VOICE1_PAN:  regs_next.pan[1]  = cfg_data[PAN_W-1:0];
                CFG_VOICE2_PAN:  regs_next.pan[2]  = cfg_data[PAN_W-1:0];
                CFG_VOICE3_PAN:  regs_next.pan[3]  = cfg_data[PAN_W-1:0];
                default:         regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICE_SLOTS; i++)
            begin
                regs_reg.gain[i] <= Q15_ONE;
                regs_reg.pan[i]  <= '0;
            end
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

// File: hdl/svm_gain.sv
// effective left and right gain of the selected voice
module svm_gain
    import svm_pkg::*;
#(
    parameter int NUM_VOICES   = 4,
    parameter int OUT_CHANNELS = 2
)
(
    input  cfg_regs_t  regs,
    input  logic [1:0] voice,
    output eff_gain_t  eff
);

    logic [GAIN_W-1:0]       gain;
    logic signed [PAN_W-1:0] pan;
    logic [GAIN_W-1:0]       fac_l;
    logic [GAIN_W-1:0]       fac_r;
    logic [PROD_W-1:0]       prod_l;
    logic [PROD_W-1:0]       prod_r;
    logic [PAN_W-1:0]        tmp_l;
    logic [PAN_W-1:0]        tmp_r;
    logic                    in_range;

    always_comb
    begin
        // clamp gain to unity and pan to +-1.0
        gain = (regs.gain[voice] > Q15_ONE) ? Q15_ONE : regs.gain[voice];
        pan  = $signed(regs.pan[voice]);
        if (pan > $signed({1'b0, Q15_ONE}))
            pan = $signed({1'b0, Q15_ONE});
        else if (pan < -$signed({1'b0, Q15_ONE}))
            pan = -$signed({1'b0, Q15_ONE});

        tmp_l = {1'b0, Q15_ONE} - pan;
        tmp_r = {1'b0, Q15_ONE} + pan;
        fac_l = (pan > 0) ? tmp_l[GAIN_W-1:0] : Q15_ONE;
        fac_r = (pan < 0) ? tmp_r[GAIN_W-1:0] : Q15_ONE;

        prod_l = gain * fac_l;
        prod_r = gain * fac_r;

        in_range = 32'(voice) < NUM_VOICES;

        eff.gain_l = (pan > 0) ? prod_l[GAIN_W+14:15] : gain;
        eff.gain_r = (pan < 0) ? prod_r[GAIN_W+14:15] : gain;
        if (!in_range)
        begin
            eff.gain_l = '0;
            eff.gain_r = '0;
        end
        if (OUT_CHANNELS < 2)
            eff.gain_r = '0;
    end

endmodule

// File: hdl/svm_accum.sv
// q30 accumulators, frame end rounding and output register
module svm_accum
    import svm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [PROD_W-1:0] prod_l,
    input  logic signed [PROD_W-1:0] prod_r,
    input  logic                     in_last,
    output logic                     take,
    output logic                     out_valid,
    input  logic                     out_stall,
    output out_word_t                out_data
);

    logic signed [ACC_W-1:0] sum_l_reg, sum_l_next;
    logic signed [ACC_W-1:0] sum_r_reg, sum_r_next;
    logic                    out_valid_reg, out_valid_next;
    out_word_t               out_data_reg, out_data_next;
    logic signed [ACC_W-1:0] new_l;
    logic signed [ACC_W-1:0] new_r;
    logic                    out_free;
    logic                    fire;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [ACC_W:0] s;
        s = {acc[ACC_W-1], acc} + (ACC_W+1)'(p);
        if (s[ACC_W] != s[ACC_W-1])
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            sat_add = s[ACC_W-1:0];
    endfunction

    // truncate toward zero to q15, then saturate to 16 bits
    function automatic logic signed [SAMPLE_W-1:0] to_out(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0]    t;
        logic signed [ACC_W-16:0]   q;
        t = s + (s[ACC_W-1] ? ACC_W'(32767) : ACC_W'(0));
        q = t[ACC_W-1:15];
        if (q > (ACC_W-14)'(32767))
            to_out = 16'sd32767;
        else if (q < -(ACC_W-14)'(32768))
            to_out = -16'sd32768;
        else
            to_out = q[SAMPLE_W-1:0];
    endfunction

    assign out_free = !out_valid_reg || !out_stall;
    assign take     = !in_last || out_free;
    assign fire     = in_valid && take;

    always_comb
    begin
        new_l          = sat_add(sum_l_reg, prod_l);
        new_r          = sat_add(sum_r_reg, prod_r);
        sum_l_next     = sum_l_reg;
        sum_r_next     = sum_r_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        if (fire)
        begin
            if (in_last)
            begin
                sum_l_next              = '0;
                sum_r_next              = '0;
                out_data_next.left_out  = to_out(new_l);
                out_data_next.right_out = to_out(new_r);
                out_valid_next          = 1'b1;
            end
            else
            begin
                sum_l_next = new_l;
                sum_r_next = new_r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_l_reg     <= '0;
            sum_r_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_l_reg     <= sum_l_next;
            sum_r_reg     <= sum_r_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_frame_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last |=> out_valid_reg)
        else $error("frame end did not produce an output word");

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last |=> (sum_l_reg == '0) && (sum_r_reg == '0))
        else $error("accumulators not cleared at frame end");

    a_held_word_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !(fire && in_last))
        else $error("frame end taken over a waiting output word");

endmodule

// File: hdl/stereo_voice_mixer_gain_pan_top.sv
// top level of the stereo voice mixer with per-voice gain and linear pan
// data path: an accepted word passes the stage 1, stage 2 and output registers in turn
// throughput: one input word per cycle while not stalled; gain/pan stage, multiply stage and
//   accumulate stage each take one word per clock
// stalls only when stage 1 is full and a frame end in stage 2 waits on a stalled output word
// reset: async active low; gains return to unity, pans to center, sums to zero
module stereo_voice_mixer_gain_pan_top
    import svm_pkg::*;
#(
    parameter int NUM_VOICES   = 4,
    parameter int OUT_CHANNELS = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input words, one voice frame each
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_data,
    // mixed stereo output words
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_data
);

    cfg_regs_t regs;
    eff_gain_t eff;

    // stage 1: input word plus its effective gains
    logic                    s1_valid_reg;
    in_word_t                s1_word_reg;
    eff_gain_t               s1_gain_reg;

    // stage 2: products in q30
    logic                    s2_valid_reg;
    logic signed [PROD_W-1:0] s2_prod_l_reg;
    logic signed [PROD_W-1:0] s2_prod_r_reg;
    logic                    s2_last_reg;

    logic                    take;
    logic                    en1;
    logic                    en2;
    logic signed [SAMPLE_W-1:0] x_right;
    logic signed [PROD_W:0]  mul_l;
    logic signed [PROD_W:0]  mul_r;

    svm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    // gains come from registers already settled before the word arrives
    svm_gain #(
        .NUM_VOICES   (NUM_VOICES),
        .OUT_CHANNELS (OUT_CHANNELS)
    ) u_gain (
        .regs  (regs),
        .voice (in_data.voice),
        .eff   (eff)
    );

    // each stage loads when empty or when the next one takes its word
    assign en2      = !s2_valid_reg || take;
    assign en1      = !s1_valid_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= in_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // mono words feed the left sample to both channels
    assign x_right = s1_word_reg.mono ? s1_word_reg.sample_left : s1_word_reg.sample_right;
    assign mul_l   = s1_word_reg.sample_left * $signed({1'b0, s1_gain_reg.gain_l});
    assign mul_r   = x_right * $signed({1'b0, s1_gain_reg.gain_r});

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_word_reg <= in_data;
            s1_gain_reg <= eff;
        end
        if (en2)
        begin
            s2_prod_l_reg <= mul_l[PROD_W-1:0];
            s2_prod_r_reg <= mul_r[PROD_W-1:0];
            s2_last_reg   <= s1_word_reg.last_in_frame;
        end
    end

    svm_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .prod_l    (s2_prod_l_reg),
        .prod_r    (s2_prod_r_reg),
        .in_last   (s2_last_reg),
        .take      (take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for the stereo voice mixer with gain and linear pan
module tb;
    import svm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // block configuration, shared by the instance and the predictor
    localparam int NUM_VOICES   = 4;
    localparam int OUT_CHANNELS = 2;

    // accumulator limits, 34-bit signed q30
    localparam longint ACC_HI = 64'sd8589934591;
    localparam longint ACC_LO = -64'sd8589934592;

    // run length guards
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_WORDS  = 85;

    localparam logic [CFG_IDX_W-1:0] GAIN_REGS [VOICE_SLOTS] =
        '{CFG_VOICE0_GAIN, CFG_VOICE1_GAIN, CFG_VOICE2_GAIN, CFG_VOICE3_GAIN};
    localparam logic [CFG_IDX_W-1:0] PAN_REGS [VOICE_SLOTS] =
        '{CFG_VOICE0_PAN, CFG_VOICE1_PAN, CFG_VOICE2_PAN, CFG_VOICE3_PAN};

    // corner values used by the extreme register settings
    localparam logic [GAIN_W-1:0] GAIN_CORNERS [5] =
        '{16'd0, 16'd1, 16'd32767, 16'd32768, 16'hFFFF};
    localparam logic [PAN_W-1:0] PAN_CORNERS [6] =
        '{17'h10000, 17'h18000, 17'h1FFFF, 17'h00000, 17'h08000, 17'h0FFFF};

    // mix predictor and store of expected output words
    class mix_scoreboard;
        logic [GAIN_W-1:0] gain_reg [VOICE_SLOTS];
        logic [PAN_W-1:0]  pan_reg  [VOICE_SLOTS];
        longint            acc_l;
        longint            acc_r;
        out_word_t         expected_mix [$];
        int                errors;
        int                words_seen;
        int                frames_seen;
        int                results_checked;

        function new();
            for (int i = 0; i < VOICE_SLOTS; i++)
            begin
                gain_reg[i] = Q15_ONE;
                pan_reg[i]  = '0;
            end
            acc_l = 0;
            acc_r = 0;
            errors = 0;
            words_seen = 0;
            frames_seen = 0;
            results_checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_VOICE0_GAIN: gain_reg[0] = val[GAIN_W-1:0];
                CFG_VOICE1_GAIN: gain_reg[1] = val[GAIN_W-1:0];
                CFG_VOICE2_GAIN: gain_reg[2] = val[GAIN_W-1:0];
                CFG_VOICE3_GAIN: gain_reg[3] = val[GAIN_W-1:0];
                CFG_VOICE0_PAN:  pan_reg[0]  = val[PAN_W-1:0];
                CFG_VOICE1_PAN:  pan_reg[1]  = val[PAN_W-1:0];
                CFG_VOICE2_PAN:  pan_reg[2]  = val[PAN_W-1:0];
                CFG_VOICE3_PAN:  pan_reg[3]  = val[PAN_W-1:0];
                default: ;
            endcase
        endfunction

        function longint sat_acc(longint a);
            if (a > ACC_HI)
                return ACC_HI;
            if (a < ACC_LO)
                return ACC_LO;
            return a;
        endfunction

        // q30 to q15, truncating toward zero, then saturate
        function logic [SAMPLE_W-1:0] to_q15(longint a);
            longint q;
            q = a / 32768;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            return q[SAMPLE_W-1:0];
        endfunction

        function void predict_word(in_word_t w);
            longint    g;
            longint    p;
            longint    gl;
            longint    gr;
            longint    sl;
            longint    xr;
            out_word_t want;
            int        v;
            v = int'(w.voice);
            words_seen++;
            if (v < NUM_VOICES)
            begin
                g = longint'(gain_reg[v]);
                if (g > 32768)
                    g = 32768;
                p = longint'($signed(pan_reg[v]));
                if (p > 32768)
                    p = 32768;
                if (p < -32768)
                    p = -32768;
                gl = (p > 0) ? (g * (32768 - p)) / 32768 : g;
                gr = (p < 0) ? (g * (32768 + p)) / 32768 : g;
                sl = longint'($signed(w.sample_left));
                xr = w.mono ? sl : longint'($signed(w.sample_right));
                acc_l = sat_acc(acc_l + sl * gl);
                if (OUT_CHANNELS > 1)
                    acc_r = sat_acc(acc_r + xr * gr);
            end
            if (w.last_in_frame)
            begin
                want.left_out  = to_q15(acc_l);
                want.right_out = (OUT_CHANNELS > 1) ? to_q15(acc_r) : '0;
                expected_mix.push_back(want);
                acc_l = 0;
                acc_r = 0;
                frames_seen++;
            end
        endfunction

        function void check_mix(out_word_t got);
            out_word_t want;
            if (expected_mix.size() == 0)
            begin
                $display("%0t: unexpected output word, expected none, got left %0d right %0d",
                         $time, got.left_out, got.right_out);
                errors++;
                return;
            end
            want = expected_mix.pop_front();
            results_checked++;
            if (got.left_out !== want.left_out)
            begin
                $display("%0t: left_out mismatch, expected %0d, got %0d",
                         $time, want.left_out, got.left_out);
                errors++;
            end
            if (got.right_out !== want.right_out)
            begin
                $display("%0t: right_out mismatch, expected %0d, got %0d",
                         $time, want.right_out, got.right_out);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_data;

    mix_scoreboard sb;

    // shadow of in_valid so it is never assigned twice in one step
    bit offering;
    // sender burst bookkeeping
    int burst_left;
    // long receiver hold-off requests, served by the receiver process
    int hold_asks;
    int hold_served;
    int cycles;
    int settings_used;

    stereo_voice_mixer_gain_pan_top #(
        .NUM_VOICES   (NUM_VOICES),
        .OUT_CHANNELS (OUT_CHANNELS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // global watchdog, also counts cycles for the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // output monitor: every accepted output word is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_mix(out_data);
    end

    // receiver: stall patterns of its own, plus long hold-offs on request
    initial
    begin
        int mode;
        int run;
        int tick;
        int held;
        out_stall <= 1'b0;
        tick = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(20, 120);
            repeat (run)
            begin
                @(posedge clk);
                tick++;
                if (hold_asks != hold_served)
                begin
                    // hold the output long enough for the pipeline to fill up
                    out_stall <= 1'b1;
                    held = 0;
                    while (held < HOLD_CYCLES)
                    begin
                        @(posedge clk);
                        held++;
                    end
                    hold_served++;
                end
                else
                begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 99) < 40);
                        2: out_stall <= ((tick % 4) == 3);
                        default: out_stall <= ($urandom_range(0, 99) < 85);
                    endcase
                end
            end
        end
    end

    // offer one word and wait until the block takes it
    task automatic send_word(input in_word_t w);
        in_valid <= 1'b1;
        in_data  <= w;
        offering = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.predict_word(w);
    endtask

    task automatic drop_valid();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // bursts of random length, random gaps between them
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                drop_valid();
                repeat (gap)
                    @(posedge clk);
            end
            // now and then a long stretch with no idling
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 15);
        end
    endtask

    // block is idle: nothing expected and any non-final word drained through
    task automatic wait_idle();
        drop_valid();
        while (sb.expected_mix.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain(int style);
        case (style)
            0: return GAIN_CORNERS[$urandom_range(0, 4)];
            1: return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [PAN_W-1:0] pick_pan(int style);
        int p;
        case (style)
            0: return PAN_CORNERS[$urandom_range(0, 5)];
            1: return PAN_W'($urandom);
            default:
            begin
                p = int'($urandom_range(0, 65536)) - 32768;
                return PAN_W'(p);
            end
        endcase
    endfunction

    // full register set, sometimes with a write to an unused index
    task automatic configure(input int style);
        for (int i = 0; i < VOICE_SLOTS; i++)
            write_reg(GAIN_REGS[i], CFG_DATA_W'(pick_gain(style)));
        for (int i = 0; i < VOICE_SLOTS; i++)
            write_reg(PAN_REGS[i], pick_pan(style));
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_IDX_W'($urandom_range(CFG_VOICE3_PAN + 1, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic in_word_t make_word(int v, int sl, int sr, bit mono, bit last);
        in_word_t w;
        w.voice         = 2'(v);
        w.sample_left   = SAMPLE_W'(sl);
        w.sample_right  = SAMPLE_W'(sr);
        w.mono          = mono;
        w.last_in_frame = last;
        return w;
    endfunction

    // samples lean toward the rails, loud frames push the sums into saturation
    function automatic logic [SAMPLE_W-1:0] pick_sample(bit loud, bit neg);
        int r;
        r = $urandom_range(0, 99);
        if (loud && r < 80)
            return neg ? 16'h8000 : 16'h7FFF;
        if (r < 8)
            return 16'h8000;
        if (r < 16)
            return 16'h7FFF;
        if (r < 20)
            return 16'hFFFF;
        if (r < 22)
            return 16'h0000;
        return SAMPLE_W'($urandom);
    endfunction

    // main stimulus
    initial
    begin
        in_word_t w;
        int       len;
        int       words;
        bit       loud;
        bit       neg;
        int       styles [6];
        styles = '{0, 1, 2, 0, 1, 2};

        sb = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        offering  = 1'b0;
        burst_left = 0;
        hold_asks = 0;
        hold_served = 0;
        cycles = 0;
        settings_used = 1;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unity gain, center pan
        // rails on a one-word frame, stereo and mono
        send_word(make_word(0, 32767, -32768, 1'b0, 1'b1));
        pace();
        send_word(make_word(1, -32768, 12345, 1'b1, 1'b1));
        pace();
        // all four voices at the rails, sum clips in both directions
        for (int v = 0; v < VOICE_SLOTS; v++)
        begin
            send_word(make_word(v, 32767, -32768, 1'b0, v == VOICE_SLOTS - 1));
            pace();
        end
        // accumulator saturates high, then falls back; truncation toward zero shows on the sum
        for (int i = 0; i < 17; i++)
        begin
            send_word(make_word(2, (i < 9) ? 32767 : -32768, 0, 1'b1, i == 16));
            pace();
        end

        // gain above unity, zero gain, pans beyond both ends, unused indexes
        wait_idle();
        write_reg(CFG_VOICE0_GAIN, 17'h0FFFF);
        write_reg(CFG_VOICE1_GAIN, 17'd0);
        write_reg(CFG_VOICE2_GAIN, 17'd12345);
        write_reg(CFG_VOICE3_GAIN, 17'd32768);
        write_reg(CFG_VOICE0_PAN, 17'h0FFFF);
        write_reg(CFG_VOICE1_PAN, 17'h10000);
        write_reg(CFG_VOICE2_PAN, 17'h18000);
        write_reg(CFG_VOICE3_PAN, 17'h08000);
        write_reg(CFG_IDX_W'(CFG_VOICE3_PAN + 1), 17'h1FFFF);
        write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), 17'h00000);
        cfg_we <= 1'b0;
        settings_used++;
        for (int v = 0; v < VOICE_SLOTS; v++)
        begin
            send_word(make_word(v, -32767, 32767, v[0], 1'b1));
            pace();
        end

        // random phases, each under its own register setting
        foreach (styles[ph])
        begin
            wait_idle();
            configure(styles[ph]);
            words = 0;
            while (words < PHASE_WORDS)
            begin
                // mostly short frames, now and then a long one that may be loud
                if ($urandom_range(0, 9) == 0)
                begin
                    len  = $urandom_range(9, 16);
                    loud = 1'($urandom_range(0, 1));
                end
                else
                begin
                    len  = $urandom_range(1, 5);
                    loud = 1'b0;
                end
                neg = 1'($urandom_range(0, 1));
                for (int k = 0; k < len; k++)
                begin
                    w.voice         = 2'($urandom_range(0, 3));
                    w.sample_left   = pick_sample(loud, neg);
                    w.sample_right  = pick_sample(loud, !neg);
                    w.mono          = ($urandom_range(0, 2) == 0);
                    w.last_in_frame = (k == len - 1);
                    send_word(w);
                    pace();
                    words++;
                end
            end
        end

        // backpressure: receiver holds off while words keep coming back to back
        wait_idle();
        hold_asks++;
        for (int i = 0; i < 40; i++)
        begin
            w.voice         = 2'($urandom_range(0, 3));
            w.sample_left   = pick_sample(1'b0, 1'b0);
            w.sample_right  = pick_sample(1'b0, 1'b0);
            w.mono          = 1'($urandom_range(0, 1));
            w.last_in_frame = 1'b1;
            send_word(w);
        end

        // drain and settle
        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        while (sb.expected_mix.size() != 0)
        begin
            w = '0;
            $display("%0t: missing output word, expected left %0d right %0d, got none",
                     $time, sb.expected_mix[0].left_out, sb.expected_mix[0].right_out);
            void'(sb.expected_mix.pop_front());
            sb.errors++;
        end

        $display("run covered %0d input words in %0d frames under %0d register settings",
                 sb.words_seen, sb.frames_seen, settings_used);
        $display("%0d mixed words checked, %0d errors, %0d cycles",
                 sb.results_checked, sb.errors, cycles);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
